FILE: src/spdc_pkg.sv
// Shared types and constants for the stepped pump dosing controller.
package spdc_pkg;

    localparam int unsigned VOL_W    = 24;
    localparam int unsigned RATE_W   = 20;
    localparam int unsigned MS_W     = 32;
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned PROD_W   = 34;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 32;
    localparam int unsigned IN_DAT_W  = 64;
    localparam int unsigned OUT_DAT_W = 40;
    localparam int unsigned DIV_CNT_W = 6;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 6'd33;
    localparam logic [PROD_W-1:0]    MS_PER_S = 34'd1000;

    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESET  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FLOW_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_VOL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIX_DELAY = 2'd2;

    typedef struct packed {
        logic load_item;
        logic eval;
        logic mul;
        logic div_step;
    } t_dp_cmd;

    typedef struct packed {
        logic need_run;
    } t_dp_stat;

endpackage

FILE: src/spdc_ctrl.sv
// Sequencing state machine for the dosing controller.
module spdc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_free,
    input  spdc_pkg::t_dp_stat i_stat,
    output logic               o_in_ready,
    output logic               o_out_load,
    output spdc_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MUL,
        S_DIV,
        S_OUT
    } t_state;

    t_state                              r_state;
    logic [spdc_pkg::DIV_CNT_W-1:0]      r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_state <= i_stat.need_run ? S_MUL : S_OUT;
                end
                S_MUL: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == spdc_pkg::DIV_LAST) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_load     = (r_state == S_OUT) && i_out_free;
    assign o_cmd.load_item = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.eval      = (r_state == S_EVAL);
    assign o_cmd.mul       = (r_state == S_MUL);
    assign o_cmd.div_step  = (r_state == S_DIV);

endmodule

FILE: src/spdc_dp.sv
// Datapath: dose state, configuration registers and run-length divider.
module spdc_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [spdc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [spdc_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    input  logic [spdc_pkg::CMD_W-1:0]        i_command,
    input  logic [spdc_pkg::VOL_W-1:0]        i_start_volume_ul,
    input  logic                              i_pump_running,
    input  logic [spdc_pkg::MS_W-1:0]         i_now_ms,
    input  spdc_pkg::t_dp_cmd                 i_cmd,
    output spdc_pkg::t_dp_stat                o_stat,
    output logic                              o_run_pump,
    output logic [spdc_pkg::MS_W-1:0]         o_run_time_ms,
    output logic                              o_active,
    output logic                              o_busy_res
);

    logic [spdc_pkg::RATE_W-1:0] r_flow_rate;
    logic [spdc_pkg::VOL_W-1:0]  r_step_vol;
    logic [spdc_pkg::MS_W-1:0]   r_mix_delay;

    logic                        r_active;
    logic                        r_aw_pump;
    logic                        r_aw_mix;
    logic [spdc_pkg::VOL_W-1:0]  r_remaining;
    logic [spdc_pkg::MS_W-1:0]   r_mix_start;

    logic [spdc_pkg::CMD_W-1:0]  r_command;
    logic [spdc_pkg::VOL_W-1:0]  r_start_vol;
    logic                        r_pump_on;
    logic [spdc_pkg::MS_W-1:0]   r_now;

    logic                        r_run;
    logic [spdc_pkg::VOL_W-1:0]  r_step;
    logic [spdc_pkg::PROD_W-1:0] r_quo;
    logic [spdc_pkg::RATE_W:0]   r_rem;

    logic                        n_active;
    logic                        n_aw_pump;
    logic                        n_aw_mix;
    logic [spdc_pkg::VOL_W-1:0]  n_remaining;
    logic [spdc_pkg::MS_W-1:0]   n_mix_start;
    logic                        n_run;
    logic [spdc_pkg::VOL_W-1:0]  n_step;
    logic [spdc_pkg::MS_W-1:0]   n_elapsed;
    logic [spdc_pkg::RATE_W:0]   n_rem_shift;
    logic [spdc_pkg::RATE_W:0]   n_rem_diff;
    logic                        n_q_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flow_rate <= '0;
            r_step_vol  <= '0;
            r_mix_delay <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                spdc_pkg::REG_FLOW_RATE: r_flow_rate <= i_cfg_data[spdc_pkg::RATE_W-1:0];
                spdc_pkg::REG_STEP_VOL:  r_step_vol  <= i_cfg_data[spdc_pkg::VOL_W-1:0];
                spdc_pkg::REG_MIX_DELAY: r_mix_delay <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_active    = r_active;
        n_aw_pump   = r_aw_pump;
        n_aw_mix    = r_aw_mix;
        n_remaining = r_remaining;
        n_mix_start = r_mix_start;
        n_run       = 1'b0;
        n_step      = (r_remaining < r_step_vol) ? r_remaining : r_step_vol;
        n_elapsed   = r_now - r_mix_start;
        case (r_command)
            spdc_pkg::CMD_UPDATE: begin
                if (r_active) begin
                    if ((r_step_vol == '0) || (r_flow_rate == '0)) begin
                        n_active = 1'b0;
                    end else if (r_pump_on) begin
                        n_aw_pump = 1'b1;
                    end else if (r_aw_pump) begin
                        n_aw_pump   = 1'b0;
                        n_aw_mix    = 1'b1;
                        n_mix_start = r_now;
                    end else if (!(r_aw_mix && (n_elapsed < r_mix_delay))) begin
                        n_aw_mix = 1'b0;
                        if (r_remaining == '0) begin
                            n_active = 1'b0;
                        end else begin
                            n_run       = 1'b1;
                            n_remaining = r_remaining - n_step;
                            n_aw_pump   = 1'b1;
                        end
                    end
                end
            end
            spdc_pkg::CMD_START: begin
                if ((r_start_vol != '0) && !r_active) begin
                    n_remaining = r_start_vol;
                    n_mix_start = '0;
                    n_aw_pump   = 1'b0;
                    n_aw_mix    = 1'b0;
                    n_active    = 1'b1;
                end
            end
            spdc_pkg::CMD_RESET: begin
                n_active    = 1'b0;
                n_aw_pump   = 1'b0;
                n_aw_mix    = 1'b0;
                n_remaining = '0;
                n_mix_start = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_aw_pump   <= 1'b0;
            r_aw_mix    <= 1'b0;
            r_remaining <= '0;
            r_mix_start <= '0;
        end else if (i_cmd.eval) begin
            r_active    <= n_active;
            r_aw_pump   <= n_aw_pump;
            r_aw_mix    <= n_aw_mix;
            r_remaining <= n_remaining;
            r_mix_start <= n_mix_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_command   <= i_command;
            r_start_vol <= i_start_volume_ul;
            r_pump_on   <= i_pump_running;
            r_now       <= i_now_ms;
        end
        if (i_cmd.eval) begin
            r_run  <= n_run;
            r_step <= n_step;
        end
    end

    assign n_rem_shift = {r_rem[spdc_pkg::RATE_W-1:0], r_quo[spdc_pkg::PROD_W-1]};
    assign n_rem_diff  = n_rem_shift - {1'b0, r_flow_rate};
    assign n_q_bit     = (n_rem_shift >= {1'b0, r_flow_rate});

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_quo <= spdc_pkg::PROD_W'(r_step) * spdc_pkg::MS_PER_S;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[spdc_pkg::PROD_W-2:0], n_q_bit};
            r_rem <= n_q_bit ? n_rem_diff : n_rem_shift;
        end
    end

    always_comb begin
        if (!r_run) begin
            o_run_time_ms = '0;
        end else if (r_quo[spdc_pkg::PROD_W-1:spdc_pkg::MS_W] != '0) begin
            o_run_time_ms = '1;
        end else if (r_quo == '0) begin
            o_run_time_ms = spdc_pkg::MS_W'(1);
        end else begin
            o_run_time_ms = r_quo[spdc_pkg::MS_W-1:0];
        end
    end

    assign o_stat.need_run = n_run;
    assign o_run_pump      = r_run;
    assign o_active        = r_active;
    assign o_busy_res      = r_active | r_pump_on;

endmodule

FILE: src/stepped_pump_dosing_controller_unit.sv
// An item that starts no pump run is evaluated and then loaded into the output register;
// one that starts a run first goes through a multiply and a 34-step restoring divider.
// Throughput: one item at a time; the next item is taken once the current result
// has moved into the output register, which can still be waiting on the sink.
// Reset: synchronous, active low; clears configuration, dose state and output valid.
// Top level of the stepped pump dosing controller.
module stepped_pump_dosing_controller_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // start_volume_ul [23:0], pump_running [24], now_ms [56:25], zero fill above.
    input  logic [spdc_pkg::IN_DAT_W-1:0]     s_axis_tdata,
    // command [1:0].
    input  logic [spdc_pkg::CMD_W-1:0]        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // run_pump [0], run_time_ms [32:1], active [33], busy_res [34], zero fill above.
    output logic [spdc_pkg::OUT_DAT_W-1:0]    m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [spdc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [spdc_pkg::CFG_DAT_W-1:0]    i_cfg_data
);

    spdc_pkg::t_dp_cmd                  w_cmd;
    spdc_pkg::t_dp_stat                 w_stat;
    logic                               w_out_load;
    logic                               w_out_free;
    logic                               w_run_pump;
    logic [spdc_pkg::MS_W-1:0]          w_run_time_ms;
    logic                               w_active;
    logic                               w_busy_res;

    logic                               r_out_valid;
    logic [spdc_pkg::OUT_DAT_W-1:0]     r_out_data;

    assign w_out_free = !r_out_valid || m_axis_tready;

    spdc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_free (w_out_free),
        .i_stat     (w_stat),
        .o_in_ready (s_axis_tready),
        .o_out_load (w_out_load),
        .o_cmd      (w_cmd)
    );

    spdc_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_command         (s_axis_tuser),
        .i_start_volume_ul (s_axis_tdata[23:0]),
        .i_pump_running    (s_axis_tdata[24]),
        .i_now_ms          (s_axis_tdata[56:25]),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .o_run_pump        (w_run_pump),
        .o_run_time_ms     (w_run_time_ms),
        .o_active          (w_active),
        .o_busy_res        (w_busy_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= {5'b0, w_busy_res, w_active, w_run_time_ms, w_run_pump};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

FILE: test/stepped_pump_dosing_controller_unit_test.sv
// Self-checking testbench for the stepped pump dosing controller unit.
module stepped_pump_dosing_controller_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [spdc_pkg::CMD_W-1:0]     CMD_SPARE = 2'd3;
    localparam logic [spdc_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int STALL_LIMIT       = 5000;
    localparam int ITEMS_PER_SETTING = 72;

    typedef struct packed {
        logic                      run_pump;
        logic [spdc_pkg::MS_W-1:0] run_time_ms;
        logic                      active;
        logic                      busy;
    } t_dose_result;

    class dose_scoreboard;
        logic [spdc_pkg::RATE_W-1:0] flow_rate = '0;
        logic [spdc_pkg::VOL_W-1:0]  step_vol  = '0;
        logic [spdc_pkg::MS_W-1:0]   mix_delay = '0;
        logic                        dosing    = 1'b0;
        logic                        wait_pump = 1'b0;
        logic                        wait_mix  = 1'b0;
        logic [spdc_pkg::VOL_W-1:0]  remaining = '0;
        logic [spdc_pkg::MS_W-1:0]   mix_start = '0;
        logic                        last_run  = 1'b0;
        t_dose_result                pending_results[$];
        int errors = 0, n_items = 0, n_results = 0, n_runs = 0;
        int n_saturated = 0, n_floored = 0, n_doses_done = 0;

        function void write_reg(input logic [spdc_pkg::CFG_IDX_W-1:0] idx,
                                input logic [spdc_pkg::CFG_DAT_W-1:0] val);
            case (idx)
                spdc_pkg::REG_FLOW_RATE: flow_rate = val[spdc_pkg::RATE_W-1:0];
                spdc_pkg::REG_STEP_VOL:  step_vol  = val[spdc_pkg::VOL_W-1:0];
                spdc_pkg::REG_MIX_DELAY: mix_delay = val;
                default: ;
            endcase
        endfunction

        function void take_item(input logic [spdc_pkg::CMD_W-1:0] cmd,
                                input logic [spdc_pkg::IN_DAT_W-1:0] data);
            logic [spdc_pkg::VOL_W-1:0] vol;
            logic                       pump_on;
            logic [spdc_pkg::MS_W-1:0]  now;
            logic [spdc_pkg::VOL_W-1:0] portion;
            logic [63:0]                span;
            t_dose_result               res;
            vol     = data[23:0];
            pump_on = data[24];
            now     = data[56:25];
            res     = '0;
            case (cmd)
                spdc_pkg::CMD_UPDATE: if (dosing) begin
                    if (step_vol == '0 || flow_rate == '0) begin
                        dosing = 1'b0;
                    end else if (pump_on) begin
                        wait_pump = 1'b1;
                    end else if (wait_pump) begin
                        wait_pump = 1'b0;
                        wait_mix  = 1'b1;
                        mix_start = now;
                    end else if (!wait_mix || (now - mix_start) >= mix_delay) begin
                        wait_mix = 1'b0;
                        if (remaining == '0) begin
                            dosing = 1'b0;
                            n_doses_done++;
                        end else begin
                            portion = (remaining < step_vol) ? remaining : step_vol;
                            span = (64'(portion) * 64'd1000) / 64'(flow_rate);
                            if (span == 64'd0) begin
                                span = 64'd1;
                                n_floored++;
                            end else if (span > 64'hFFFF_FFFF) begin
                                span = 64'hFFFF_FFFF;
                                n_saturated++;
                            end
                            res.run_pump    = 1'b1;
                            res.run_time_ms = span[spdc_pkg::MS_W-1:0];
                            remaining       = remaining - portion;
                            wait_pump       = 1'b1;
                            n_runs++;
                        end
                    end
                end
                spdc_pkg::CMD_START: if (vol != '0 && !dosing) begin
                    remaining = vol;
                    mix_start = '0;
                    wait_pump = 1'b0;
                    wait_mix  = 1'b0;
                    dosing    = 1'b1;
                end
                spdc_pkg::CMD_RESET: begin
                    dosing    = 1'b0;
                    wait_pump = 1'b0;
                    wait_mix  = 1'b0;
                    remaining = '0;
                    mix_start = '0;
                end
                default: ;
            endcase
            res.active = dosing;
            res.busy   = dosing | pump_on;
            last_run   = res.run_pump;
            pending_results.push_back(res);
            n_items++;
        endfunction

        function void check_result(input logic [spdc_pkg::OUT_DAT_W-1:0] data);
            t_dose_result want;
            logic [31:0]  got_f[4];
            logic [31:0]  want_f[4];
            string        names[4];
            n_results++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t ns: result %h arrived with none expected", $time, data);
                return;
            end
            want   = pending_results.pop_front();
            names  = '{"run_pump", "run_time_ms", "active", "busy_res"};
            got_f  = '{32'(data[0]), data[32:1], 32'(data[33]), 32'(data[34])};
            want_f = '{32'(want.run_pump), want.run_time_ms, 32'(want.active), 32'(want.busy)};
            for (int k = 0; k < 4; k++) begin
                if (got_f[k] !== want_f[k]) begin
                    errors++;
                    $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                             $time, names[k], want_f[k], got_f[k]);
                end
            end
        endfunction
    endclass

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [spdc_pkg::IN_DAT_W-1:0]  s_axis_tdata  = '0;
    logic [spdc_pkg::CMD_W-1:0]     s_axis_tuser  = spdc_pkg::CMD_UPDATE;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [spdc_pkg::OUT_DAT_W-1:0] m_axis_tdata;
    logic                           i_cfg_we      = 1'b0;
    logic [spdc_pkg::CFG_IDX_W-1:0] i_cfg_idx     = spdc_pkg::REG_FLOW_RATE;
    logic [spdc_pkg::CFG_DAT_W-1:0] i_cfg_data    = '0;

    dose_scoreboard            sb = new();
    int                        send_idle_pct  = 0;
    int                        recv_idle_pct  = 0;
    int                        stall_cycles   = 0;
    int                        settings_used  = 0;
    int                        pump_left      = 0;
    logic [spdc_pkg::MS_W-1:0] tick_ms        = '0;
    logic                      moved;

    stepped_pump_dosing_controller_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            moved = 1'b0;
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata);
                moved = 1'b1;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                sb.take_item(s_axis_tuser, s_axis_tdata);
                moved = 1'b1;
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Timed out after %0d cycles without an item moving.", STALL_LIMIT);
                $display("stepped_pump_dosing_controller_unit regression: fail");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [spdc_pkg::CMD_W-1:0] cmd,
                             input logic [spdc_pkg::VOL_W-1:0] vol,
                             input logic pump_on, input logic [spdc_pkg::MS_W-1:0] now);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {7'd0, now, pump_on, vol};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic program_regs(input logic [spdc_pkg::CFG_DAT_W-1:0] rate_val,
                                input logic [spdc_pkg::CFG_DAT_W-1:0] step_val,
                                input logic [spdc_pkg::CFG_DAT_W-1:0] delay_val);
        logic [spdc_pkg::CFG_IDX_W-1:0] idxs[4];
        logic [spdc_pkg::CFG_DAT_W-1:0] vals[4];
        idxs = '{spdc_pkg::REG_FLOW_RATE, spdc_pkg::REG_STEP_VOL, spdc_pkg::REG_MIX_DELAY,
                 REG_SPARE};
        vals = '{rate_val, step_val, delay_val, $urandom()};
        settle();
        for (int k = 0; k < 4; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idxs[k];
            i_cfg_data <= vals[k];
            sb.write_reg(idxs[k], vals[k]);
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic run_directed();
        program_regs(32'd1000, 32'd100, 32'd5);
        send_item(spdc_pkg::CMD_UPDATE, 24'd0, 1'b1, 32'd0);
        send_item(spdc_pkg::CMD_START, 24'd0, 1'b0, 32'd1);
        send_item(CMD_SPARE, 24'hFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        send_item(spdc_pkg::CMD_START, 24'd150, 1'b0, 32'd2);
        send_item(spdc_pkg::CMD_START, 24'd5, 1'b0, 32'd3);
        send_item(spdc_pkg::CMD_UPDATE, 24'd0, 1'b0, 32'd10);
        send_item(spdc_pkg::CMD_UPDATE, 24'd0, 1'b1, 32'd11);
        send_item(spdc_pkg::CMD_UPDATE, 24'd0, 1'b0, 32'd20);
        send_item(spdc_pkg::CMD_UPDATE, 24'd0, 1'b0, 32'd24);
        send_item(spdc_pkg::CMD_UPDATE, 24'd0, 1'b0, 32'd25);
        send_item(spdc_pkg::CMD_UPDATE, 24'd0, 1'b0, 32'd26);
        send_item(spdc_pkg::CMD_UPDATE, 24'd0, 1'b0, 32'd31);
        // The mix wait below straddles the wrap of the millisecond counter.
        send_item(spdc_pkg::CMD_START, 24'd150, 1'b0, 32'd40);
        send_item(spdc_pkg::CMD_UPDATE, 24'd0, 1'b0, 32'hFFFF_FFFC);
        send_item(spdc_pkg::CMD_UPDATE, 24'd0, 1'b0, 32'hFFFF_FFFD);
        send_item(spdc_pkg::CMD_UPDATE, 24'd0, 1'b0, 32'd1);
        send_item(spdc_pkg::CMD_UPDATE, 24'd0, 1'b0, 32'd2);
        send_item(spdc_pkg::CMD_RESET, 24'd0, 1'b1, 32'd3);
        program_regs(32'd1, 32'hFF_FFFF, 32'd0);
        send_item(spdc_pkg::CMD_START, 24'hFF_FFFF, 1'b0, 32'd0);
        send_item(spdc_pkg::CMD_UPDATE, 24'd0, 1'b0, 32'd0);
        program_regs(32'hF_FFFF, 32'd1, 32'hFFFF_FFFF);
        send_item(spdc_pkg::CMD_UPDATE, 24'd0, 1'b0, 32'd5);
        send_item(spdc_pkg::CMD_UPDATE, 24'd0, 1'b0, 32'd4);
        send_item(spdc_pkg::CMD_START, 24'd2, 1'b0, 32'd6);
        send_item(spdc_pkg::CMD_UPDATE, 24'd0, 1'b0, 32'd7);
        program_regs(32'hF_FFFF, 32'd0, 32'hFFFF_FFFF);
        send_item(spdc_pkg::CMD_UPDATE, 24'd0, 1'b0, 32'd8);
        program_regs(32'd0, 32'd100, 32'd0);
        send_item(spdc_pkg::CMD_START, 24'd7, 1'b0, 32'd9);
        send_item(spdc_pkg::CMD_UPDATE, 24'd0, 1'b0, 32'd10);
    endtask

    task automatic random_setting();
        logic [spdc_pkg::CFG_DAT_W-1:0] rate_val, step_val, delay_val;
        case ($urandom_range(0, 9))
            0: begin
                if ($urandom_range(0, 1)) begin
                    rate_val = '0;
                    step_val = $urandom_range(1, 3000);
                end else begin
                    rate_val = $urandom_range(1, 5000);
                    step_val = '0;
                end
            end
            1: begin
                rate_val = $urandom_range(1, 20'hF_FFFF);
                step_val = $urandom_range(1, 24'hFF_FFFF);
            end
            2: begin
                rate_val = 32'd1;
                step_val = $urandom_range(1, 24'hFF_FFFF);
            end
            default: begin
                rate_val = $urandom_range(1, 5000);
                step_val = $urandom_range(1, 3000);
            end
        endcase
        delay_val = ($urandom_range(0, 3) == 0) ? '0 : $urandom_range(1, 30);
        program_regs(rate_val, step_val, delay_val);
    endtask

    task automatic random_item(output bit counted);
        int                         pick;
        logic [spdc_pkg::CMD_W-1:0] cmd;
        logic [spdc_pkg::VOL_W-1:0] vol;
        logic                       pump_on;
        logic [31:0]                vol_wide;
        pick    = $urandom_range(0, 99);
        cmd     = spdc_pkg::CMD_UPDATE;
        vol     = spdc_pkg::VOL_W'($urandom());
        pump_on = $urandom_range(0, 1);
        if (!sb.dosing && pick < 40) begin
            cmd = spdc_pkg::CMD_START;
            if ($urandom_range(0, 9) == 0) begin
                vol = '0;
            end else if ($urandom_range(0, 9) >= 2) begin
                vol_wide = $urandom_range(1, sb.step_vol * 4 + 1);
                vol = (vol_wide > 32'hFF_FFFF) ? '1 : vol_wide[spdc_pkg::VOL_W-1:0];
            end
        end else if (pick < 4) begin
            cmd = spdc_pkg::CMD_RESET;
        end else if (pick < 7) begin
            cmd = CMD_SPARE;
        end else if (pick < 10) begin
            cmd = spdc_pkg::CMD_START;
        end else if (pick < 16) begin
            tick_ms = $urandom();
        end else begin
            pump_on = (pump_left > 0);
            if (pump_left > 0) pump_left--;
            tick_ms += $urandom_range(0, 12);
        end
        counted = !(cmd == CMD_SPARE ||
                    (cmd == spdc_pkg::CMD_START && (vol == '0 || sb.dosing)));
        send_item(cmd, vol, pump_on, tick_ms);
        if (sb.last_run) pump_left = $urandom_range(0, 3);
    endtask

    initial begin
        bit counted;
        int done_items;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 26;
        recv_idle_pct = 57;
        run_directed();
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 26 : (ph == 1) ? 57 : 0;
            recv_idle_pct = (ph == 0) ? 57 : (ph == 1) ? 26 : 0;
            for (int s = 0; s < 4; s++) begin
                random_setting();
                done_items = 0;
                while (done_items < ITEMS_PER_SETTING) begin
                    random_item(counted);
                    done_items += counted;
                end
            end
        end
        settle();
        repeat (50) @(negedge i_clk);
        $display("Checked %0d items and %0d results over %0d register settings %s",
                 sb.n_items, sb.n_results, settings_used, "and three stall mixes.");
        $display("Runs issued: %0d (%0d saturated, %0d raised to 1 ms); doses completed: %0d.",
                 sb.n_runs, sb.n_saturated, sb.n_floored, sb.n_doses_done);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("stepped_pump_dosing_controller_unit regression: pass");
        end else begin
            $display("stepped_pump_dosing_controller_unit regression: fail");
        end
        $finish;
    end

endmodule
